// File: hw/rtl/frp_pkg.sv
// Package for the free-space ray point generator.
// Holds the fixed parameters, register codes, payload types and small helpers.
// Used by every module of the block; depends on nothing.
package frp_pkg;

    localparam int HFOV_MRAD         = 1500;
    localparam int VFOV_MRAD         = 1000;
    localparam int RANGE_MM          = 10000;
    localparam int PITCH_OFFSET_MRAD = 175;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Z    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Z   = 3'd7;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;

    localparam int XFORM_WORDS = 12;
    localparam int TR_BASE     = 9;

    // Angle division: |numerator| < 2^PROD_W, scaled by 2^ANG_FRAC, divided by
    // DEN_SCALE * (size - 1). The divisor is at least DEN_SCALE, so the top
    // SEED_W dividend bits are always below it and seed the remainder.
    localparam int ANG_FRAC  = 28;
    localparam int PROD_W    = 26;
    localparam int NUM_W     = PROD_W + ANG_FRAC;
    localparam int DEN_W     = 24;
    localparam int DEN_SCALE = 2000;
    localparam int Q_W       = 44;
    localparam int SEED_W    = NUM_W - Q_W;

    localparam longint TWO_PI_Q28 = 1686629713;
    localparam int     MOD_STEPS  = 14;
    localparam int     ANG_W      = 32;
    localparam logic signed [ANG_W-1:0] PI_S      = 32'sd843314857;
    localparam logic signed [ANG_W-1:0] TWO_PI_S  = 32'sd1686629713;
    localparam logic signed [ANG_W-1:0] HALF_PI_S = 32'sd421657428;

    localparam int CORDIC_STEPS = 28;
    localparam int XY_W         = 34;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;

    localparam logic signed [31:0] RANGE_Q16 =
        32'((64'(RANGE_MM) * 65536 + 500) / 1000);

    typedef struct packed {
        logic               kind;
        logic [11:0]        pixel_col;
        logic [11:0]        pixel_row;
        logic [15:0]        depth_value;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               is_free;
    } t_out;

    // Item context that rides along the whole pipeline.
    typedef struct packed {
        logic               kind;
        logic               depth_zero;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
    } t_ctx;

    typedef struct packed {
        logic           neg;
        logic [Q_W-1:0] mag;
    } t_ang;

    typedef struct packed {
        logic signed [31:0] cy;
        logic signed [31:0] sy;
        logic signed [31:0] cp;
        logic signed [31:0] sp;
    } t_trig;

    typedef struct packed {
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
    } t_box;

    function automatic logic signed [ANG_W-1:0] atan_q28(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 32'sd210828714;
            1:  v = 32'sd124459458;
            2:  v = 32'sd65760959;
            3:  v = 32'sd33381290;
            4:  v = 32'sd16755422;
            5:  v = 32'sd8385879;
            6:  v = 32'sd4193963;
            7:  v = 32'sd2097109;
            8:  v = 32'sd1048571;
            9:  v = 32'sd524287;
            10: v = 32'sd262144;
            11: v = 32'sd131072;
            12: v = 32'sd65536;
            13: v = 32'sd32768;
            14: v = 32'sd16384;
            15: v = 32'sd8192;
            16: v = 32'sd4096;
            17: v = 32'sd2048;
            18: v = 32'sd1024;
            19: v = 32'sd512;
            20: v = 32'sd256;
            21: v = 32'sd128;
            22: v = 32'sd64;
            23: v = 32'sd32;
            24: v = 32'sd16;
            25: v = 32'sd8;
            26: v = 32'sd4;
            27: v = 32'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Shift right by s with round-half-up.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic signed [63:0] one;
        one = 64'sd1;
        return (v + (one <<< (s - 1))) >>> s;
    endfunction

endpackage

// File: hw/rtl/frp_div.sv
// Angle front end: forms the yaw and pitch numerators and divides them.
// A restoring divider retires one quotient bit per pipeline stage.
// Depends on frp_pkg.
module frp_div
    import frp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_in         i_item,
    input  logic [12:0] i_frame_width,
    input  logic [12:0] i_frame_height,
    output logic        o_valid,
    output t_ctx        o_ctx,
    output t_ang        o_ang [2]
);

    logic [12:0]        fw_c, fh_c, w1, h1;
    logic signed [14:0] yaw_a, pitch_a;
    logic signed [27:0] yaw_p, pitch_p, pitch_off;
    logic [27:0]        yaw_abs, pitch_abs;
    logic [PROD_W-1:0]  mag [2];
    logic               sgn [2];
    logic [DEN_W-1:0]   den [2];

    logic               r_v   [Q_W+1];
    t_ctx               r_ctx [Q_W+1];
    logic [DEN_W-1:0]   r_rem [2][Q_W+1];
    logic [Q_W-1:0]     r_nq  [2][Q_W+1];
    logic               r_neg [2][Q_W+1];

    logic [DEN_W-1:0]   n_rem [2][Q_W];
    logic               n_ge  [2][Q_W];

    always_comb begin
        fw_c = (i_frame_width  < 13'd2) ? 13'd2 : i_frame_width;
        fh_c = (i_frame_height < 13'd2) ? 13'd2 : i_frame_height;
        w1   = fw_c - 13'd1;
        h1   = fh_c - 13'd1;

        yaw_a     = $signed({2'b00, i_item.pixel_col, 1'b0}) - $signed({2'b00, w1});
        yaw_p     = 28'(yaw_a) * 28'(HFOV_MRAD);
        pitch_a   = $signed({2'b00, h1}) - $signed({2'b00, i_item.pixel_row, 1'b0});
        pitch_off = 28'($signed({1'b0, h1, 1'b0})) * 28'(PITCH_OFFSET_MRAD);
        pitch_p   = 28'(pitch_a) * 28'(VFOV_MRAD) - pitch_off;

        yaw_abs   = yaw_p[27]   ? 28'(-yaw_p)   : 28'(yaw_p);
        pitch_abs = pitch_p[27] ? 28'(-pitch_p) : 28'(pitch_p);
        mag[0] = yaw_abs[PROD_W-1:0];
        mag[1] = pitch_abs[PROD_W-1:0];
        sgn[0] = yaw_p[27];
        sgn[1] = pitch_p[27];

        den[0] = DEN_W'(w1) * DEN_W'(DEN_SCALE);
        den[1] = DEN_W'(h1) * DEN_W'(DEN_SCALE);
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < Q_W; k++) begin
                logic [DEN_W:0] t_w;
                t_w = {r_rem[l][k], r_nq[l][k][Q_W-1]};
                n_ge[l][k]  = t_w >= {1'b0, den[l]};
                n_rem[l][k] = n_ge[l][k] ? DEN_W'(t_w - {1'b0, den[l]}) : t_w[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Q_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < Q_W; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0].kind        <= i_item.kind;
            r_ctx[0].depth_zero  <= (i_item.depth_value == 16'd0);
            r_ctx[0].entry_index <= i_item.entry_index;
            r_ctx[0].entry_value <= i_item.entry_value;
            for (int l = 0; l < 2; l++) begin
                r_rem[l][0] <= DEN_W'(mag[l][PROD_W-1 -: SEED_W]);
                r_nq[l][0]  <= {mag[l][PROD_W-SEED_W-1:0], {ANG_FRAC{1'b0}}};
                r_neg[l][0] <= sgn[l];
            end
            for (int k = 0; k < Q_W; k++) begin
                r_ctx[k+1] <= r_ctx[k];
                for (int l = 0; l < 2; l++) begin
                    r_rem[l][k+1] <= n_rem[l][k];
                    r_nq[l][k+1]  <= {r_nq[l][k][Q_W-2:0], n_ge[l][k]};
                    r_neg[l][k+1] <= r_neg[l][k];
                end
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_ctx   = r_ctx[Q_W];
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            o_ang[l].neg = r_neg[l][Q_W];
            o_ang[l].mag = r_nq[l][Q_W];
        end
    end

endmodule

// File: hw/rtl/frp_cordic.sv
// Trigonometry: reduces both angles modulo two pi, folds them into the
// right half plane and runs a pipelined rotation CORDIC per angle.
// Depends on frp_pkg.
module frp_cordic
    import frp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_ctx  i_ctx,
    input  t_ang  i_ang [2],
    output logic  o_valid,
    output t_ctx  o_ctx,
    output t_trig o_trig
);

    // Modulo stages: one conditional subtract of a shifted two pi each.
    logic           r_mv   [MOD_STEPS];
    t_ctx           r_mctx [MOD_STEPS];
    logic [Q_W-1:0] r_m    [2][MOD_STEPS];
    logic           r_mneg [2][MOD_STEPS];
    logic [Q_W-1:0] n_m    [2][MOD_STEPS];

    // Fold stage.
    logic                    r_fv;
    t_ctx                    r_fctx;
    logic signed [ANG_W-1:0] r_fz   [2];
    logic                    r_fneg [2];
    logic signed [ANG_W-1:0] n_fz   [2];
    logic                    n_fneg [2];

    // CORDIC stages.
    logic                    r_cv   [CORDIC_STEPS];
    t_ctx                    r_cctx [CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_cx   [2][CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_cy   [2][CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_cz   [2][CORDIC_STEPS];
    logic                    r_cneg [2][CORDIC_STEPS];
    logic signed [XY_W-1:0]  n_cx   [2][CORDIC_STEPS];
    logic signed [XY_W-1:0]  n_cy   [2][CORDIC_STEPS];
    logic signed [ANG_W-1:0] n_cz   [2][CORDIC_STEPS];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < MOD_STEPS; k++) begin
                logic [Q_W-1:0] src, sub;
                src = (k == 0) ? i_ang[l].mag : r_m[l][(k == 0) ? 0 : k - 1];
                sub = Q_W'(TWO_PI_Q28) << (MOD_STEPS - 1 - k);
                n_m[l][k] = (src >= sub) ? src - sub : src;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic signed [ANG_W-1:0] r0, r1;
            logic [ANG_W-1:0]        m;
            m  = r_m[l][MOD_STEPS-1][ANG_W-1:0];
            r0 = r_mneg[l][MOD_STEPS-1] ? -$signed(m) : $signed(m);
            if (r0 > PI_S) begin
                r1 = r0 - TWO_PI_S;
            end else if (r0 < -PI_S) begin
                r1 = r0 + TWO_PI_S;
            end else begin
                r1 = r0;
            end
            if (r1 > HALF_PI_S) begin
                n_fz[l]   = r1 - PI_S;
                n_fneg[l] = 1'b1;
            end else if (r1 < -HALF_PI_S) begin
                n_fz[l]   = r1 + PI_S;
                n_fneg[l] = 1'b1;
            end else begin
                n_fz[l]   = r1;
                n_fneg[l] = 1'b0;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                logic signed [XY_W-1:0]  x, y;
                logic signed [ANG_W-1:0] z;
                if (k == 0) begin
                    x = CORDIC_GAIN_Q30;
                    y = '0;
                    z = r_fz[l];
                end else begin
                    x = r_cx[l][(k == 0) ? 0 : k - 1];
                    y = r_cy[l][(k == 0) ? 0 : k - 1];
                    z = r_cz[l][(k == 0) ? 0 : k - 1];
                end
                if (!z[ANG_W-1]) begin
                    n_cx[l][k] = x - (y >>> k);
                    n_cy[l][k] = y + (x >>> k);
                    n_cz[l][k] = z - atan_q28(k);
                end else begin
                    n_cx[l][k] = x + (y >>> k);
                    n_cy[l][k] = y - (x >>> k);
                    n_cz[l][k] = z + atan_q28(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOD_STEPS; k++) begin
                r_mv[k] <= 1'b0;
            end
            r_fv <= 1'b0;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_cv[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_mv[0] <= i_valid;
            for (int k = 1; k < MOD_STEPS; k++) begin
                r_mv[k] <= r_mv[k-1];
            end
            r_fv    <= r_mv[MOD_STEPS-1];
            r_cv[0] <= r_fv;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_cv[k] <= r_cv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mctx[0] <= i_ctx;
            for (int k = 1; k < MOD_STEPS; k++) begin
                r_mctx[k] <= r_mctx[k-1];
            end
            r_fctx    <= r_mctx[MOD_STEPS-1];
            r_cctx[0] <= r_fctx;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_cctx[k] <= r_cctx[k-1];
            end
            for (int l = 0; l < 2; l++) begin
                r_mneg[l][0] <= i_ang[l].neg;
                for (int k = 0; k < MOD_STEPS; k++) begin
                    r_m[l][k] <= n_m[l][k];
                end
                for (int k = 1; k < MOD_STEPS; k++) begin
                    r_mneg[l][k] <= r_mneg[l][k-1];
                end
                r_fz[l]      <= n_fz[l];
                r_fneg[l]    <= n_fneg[l];
                r_cneg[l][0] <= r_fneg[l];
                for (int k = 0; k < CORDIC_STEPS; k++) begin
                    r_cx[l][k] <= n_cx[l][k];
                    r_cy[l][k] <= n_cy[l][k];
                    r_cz[l][k] <= n_cz[l][k];
                end
                for (int k = 1; k < CORDIC_STEPS; k++) begin
                    r_cneg[l][k] <= r_cneg[l][k-1];
                end
            end
        end
    end

    // The fold by pi flips the sign of both results.
    always_comb begin
        logic signed [XY_W-1:0] c0, s0, c1, s1;
        c0 = r_cneg[0][CORDIC_STEPS-1] ? -r_cx[0][CORDIC_STEPS-1] : r_cx[0][CORDIC_STEPS-1];
        s0 = r_cneg[0][CORDIC_STEPS-1] ? -r_cy[0][CORDIC_STEPS-1] : r_cy[0][CORDIC_STEPS-1];
        c1 = r_cneg[1][CORDIC_STEPS-1] ? -r_cx[1][CORDIC_STEPS-1] : r_cx[1][CORDIC_STEPS-1];
        s1 = r_cneg[1][CORDIC_STEPS-1] ? -r_cy[1][CORDIC_STEPS-1] : r_cy[1][CORDIC_STEPS-1];
        o_trig.cy = 32'(c0);
        o_trig.sy = 32'(s0);
        o_trig.cp = 32'(c1);
        o_trig.sp = 32'(s1);
    end

    assign o_valid = r_cv[CORDIC_STEPS-1];
    assign o_ctx   = r_cctx[CORDIC_STEPS-1];

endmodule

// File: hw/rtl/frp_xform.sv
// Back end: forms the camera point at full range, maps it to the world frame
// with the stored transform and tests it against the exclusion box.
// Depends on frp_pkg; the transform words live here.
module frp_xform
    import frp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_ctx  i_ctx,
    input  t_trig i_trig,
    input  t_box  i_box,
    output logic  o_valid,
    output t_ctx  o_ctx,
    output t_out  o_res
);

    logic signed [31:0] r_tw [XFORM_WORDS];

    logic               r_v [6];
    t_ctx               r_ctx [6];

    logic signed [63:0] r1_pcc, r1_psc;
    logic signed [31:0] r1_sp;
    logic signed [31:0] r2_cc, r2_sc, r2_sp;
    logic signed [63:0] r3_p [3];
    logic signed [31:0] r4_cam [3];
    logic signed [63:0] r5_prod [9];
    logic signed [31:0] r5_tr [3];
    logic signed [31:0] r5_cam [3];
    logic signed [63:0] r6_w [3];
    logic signed [31:0] r6_cam [3];

    logic               load_hit;
    logic               in_box;

    // A transform load takes effect as it passes the product stage, so
    // pixels ahead of it see the old words and pixels behind the new ones.
    assign load_hit = i_en && r_v[3] && (r_ctx[3].kind == KIND_LOAD)
                      && (r_ctx[3].entry_index < 4'(XFORM_WORDS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_v[k] <= 1'b0;
            end
            for (int j = 0; j < XFORM_WORDS; j++) begin
                r_tw[j] <= ((j == 0) || (j == 4) || (j == 8)) ? 32'sd65536 : 32'sd0;
            end
        end else begin
            if (i_en) begin
                r_v[0] <= i_valid;
                for (int k = 1; k < 6; k++) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (load_hit) begin
                r_tw[r_ctx[3].entry_index] <= r_ctx[3].entry_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int k = 1; k < 6; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end
            r1_pcc <= i_trig.cy * i_trig.cp;
            r1_psc <= i_trig.sy * i_trig.cp;
            r1_sp  <= i_trig.sp;
            r2_cc  <= 32'(rnd_shift(r1_pcc, 30));
            r2_sc  <= 32'(rnd_shift(r1_psc, 30));
            r2_sp  <= r1_sp;
            r3_p[0] <= RANGE_Q16 * r2_cc;
            r3_p[1] <= RANGE_Q16 * r2_sc;
            r3_p[2] <= RANGE_Q16 * r2_sp;
            for (int i = 0; i < 3; i++) begin
                r4_cam[i] <= 32'(rnd_shift(r3_p[i], 30));
                r5_cam[i] <= r4_cam[i];
                r5_tr[i]  <= r_tw[TR_BASE + i];
                r6_cam[i] <= r5_cam[i];
                r6_w[i]   <= rnd_shift(r5_prod[3*i] + r5_prod[3*i+1] + r5_prod[3*i+2], 16)
                             + 64'(r5_tr[i]);
                for (int j = 0; j < 3; j++) begin
                    r5_prod[3*i+j] <= r_tw[3*i+j] * r4_cam[j];
                end
            end
        end
    end

    always_comb begin
        in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (!((r6_w[i] > 64'($signed(i_box.lo[i]))) &&
                  (r6_w[i] < 64'($signed(i_box.hi[i]))))) begin
                in_box = 1'b0;
            end
        end
        o_res.is_free = r_ctx[5].depth_zero && !in_box;
        o_res.point_x = o_res.is_free ? r6_cam[0] : 32'sd0;
        o_res.point_y = o_res.is_free ? r6_cam[1] : 32'sd0;
        o_res.point_z = o_res.is_free ? r6_cam[2] : 32'sd0;
    end

    assign o_valid = r_v[5];
    assign o_ctx   = r_ctx[5];

endmodule

// File: hw/rtl/freespace_ray_point_generator.sv
// Top level of the free-space ray point generator.
// Holds the configuration registers and the output register and chains
// frp_div, frp_cordic and frp_xform; depends on frp_pkg.
//
// Use: requests enter on i_in_valid / i_in_data and are taken at a clock
// edge where i_in_valid is high and o_in_stall is low. A depth pixel request
// (kind 0) gives exactly one result; a transform load request (kind 1) gives
// none and, if its index is below 12, writes that transform word in order
// with the pixels. Results leave on o_out_valid / o_out_data and are taken
// at an edge where i_out_stall is low. The path holds 95 register stages:
// 45 in the one-bit-per-stage angle divider (its seed stage and 44 quotient
// stages), 14 for the modulo reduction, one fold stage, 28 CORDIC stages,
// six in the back end and the output register; the first of them loads at
// the accepting edge.
// One request is taken in every cycle while the output is not held.
// When the receiver stalls a waiting result, the whole pipeline freezes in
// place and o_in_stall rises for as long as the result is held; nothing is
// dropped or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline, loads the default
// frame size and box, and sets the transform to the identity.
// Configuration writes on i_cfg_* take effect at once and belong to idle
// periods only.
module freespace_ray_point_generator
    import frp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;
    t_box        r_box;

    logic        r_out_valid;
    t_out        r_out_data;

    // The pipeline moves whenever the output register is free or drained.
    logic        en;

    logic        div_valid;
    t_ctx        div_ctx;
    t_ang        div_ang [2];
    logic        cor_valid;
    t_ctx        cor_ctx;
    t_trig       cor_trig;
    logic        xf_valid;
    t_ctx        xf_ctx;
    t_out        xf_res;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // Configuration registers: frame size first, then the box bounds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd640;
            r_frame_height <= 13'd480;
            r_box          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[12:0];
                CFG_BOX_LOW_X:    r_box.lo[0]    <= i_cfg_data;
                CFG_BOX_HIGH_X:   r_box.hi[0]    <= i_cfg_data;
                CFG_BOX_LOW_Y:    r_box.lo[1]    <= i_cfg_data;
                CFG_BOX_HIGH_Y:   r_box.hi[1]    <= i_cfg_data;
                CFG_BOX_LOW_Z:    r_box.lo[2]    <= i_cfg_data;
                CFG_BOX_HIGH_Z:   r_box.hi[2]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    frp_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in_valid),
        .i_item         (i_in_data),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_valid        (div_valid),
        .o_ctx          (div_ctx),
        .o_ang          (div_ang)
    );

    frp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_ctx   (div_ctx),
        .i_ang   (div_ang),
        .o_valid (cor_valid),
        .o_ctx   (cor_ctx),
        .o_trig  (cor_trig)
    );

    frp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cor_valid),
        .i_ctx   (cor_ctx),
        .i_trig  (cor_trig),
        .i_box   (r_box),
        .o_valid (xf_valid),
        .o_ctx   (xf_ctx),
        .o_res   (xf_res)
    );

    // Transform loads have done their work by now and are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= xf_valid && (xf_ctx.kind == KIND_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= xf_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hw/rtl/frp_checker.sv
// Port-level checks for the free-space ray point generator.
// Bound to the top level; depends on frp_pkg.
module frp_checker
    import frp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // A held result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("held result changed");

    // Requests are only refused while a result is held.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // A point that is not free is all zeros.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_free |->
            o_out_data.point_x == 32'sd0 && o_out_data.point_y == 32'sd0 &&
            o_out_data.point_z == 32'sd0)
        else $error("non-free result carries a point");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

endmodule

bind freespace_ray_point_generator frp_checker u_frp_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the free-space ray point generator.
// Drives random and directed requests through the valid/stall channels and
// checks each result against an in-bench prediction; depends on frp_pkg.
module tb_top;
    import frp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 400000;
    // Pipeline depth given for the block, with some margin on top.
    localparam int  DRAIN_CYCLES = 120;
    localparam int  LONG_HOLD = 600;

    localparam longint Q28_PI      = 843314857;
    localparam longint Q28_TWO_PI  = 1686629713;
    localparam longint Q28_HALF_PI = 421657428;
    localparam longint GAIN_Q30    = 652032875;
    localparam longint ATAN_TAB [28] = '{
        210828714, 124459458, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    // The scoreboard keeps its own copy of the registers and the transform,
    // predicts each pixel request and matches results in order.
    class FreePointBoard;
        longint       frame_w, frame_h;
        longint       box_lo [3];
        longint       box_hi [3];
        longint       xform [12];
        t_out         expected_points [$];
        int           errors;

        function new();
            frame_w = 640;
            frame_h = 480;
            for (int i = 0; i < 3; i++) begin
                box_lo[i] = 0;
                box_hi[i] = 0;
            end
            for (int i = 0; i < 12; i++) xform[i] = 0;
            xform[0] = 65536;
            xform[4] = 65536;
            xform[8] = 65536;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == CFG_FRAME_WIDTH) frame_w = longint'(val[12:0]);
            else if (idx == CFG_FRAME_HEIGHT) frame_h = longint'(val[12:0]);
            else if (idx[0] == 1'b0) box_lo[(idx - CFG_BOX_LOW_X) >> 1] = longint'($signed(val));
            else box_hi[(idx - CFG_BOX_LOW_X) >> 1] = longint'($signed(val));
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        // Rotation-mode CORDIC after reducing the angle into [-pi/2, pi/2].
        function void cordic_sincos(longint a, output longint c, output longint s);
            longint r, x, y, nx;
            bit     flip;
            r = a % Q28_TWO_PI;
            x = GAIN_Q30;
            y = 0;
            flip = 0;
            if (r > Q28_PI) r -= Q28_TWO_PI;
            if (r < -Q28_PI) r += Q28_TWO_PI;
            if (r > Q28_HALF_PI) begin
                r -= Q28_PI;
                flip = 1;
            end else if (r < -Q28_HALF_PI) begin
                r += Q28_PI;
                flip = 1;
            end
            for (int i = 0; i < 28; i++) begin
                if (r >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    r -= ATAN_TAB[i];
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    r += ATAN_TAB[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function t_out ray_point(t_in d);
            longint w1, h1, col, row, yaw, pitch, cy, sy, cp, sp, rng, acc, wv;
            longint cam [3];
            bit     in_box;
            t_out   o;
            w1 = (frame_w < 2 ? 2 : frame_w) - 1;
            h1 = (frame_h < 2 ? 2 : frame_h) - 1;
            col = longint'(d.pixel_col);
            row = longint'(d.pixel_row);
            yaw = ((2 * col - w1) * HFOV_MRAD * 64'sd268435456) / (2000 * w1);
            pitch = (((h1 - 2 * row) * VFOV_MRAD - 2 * h1 * PITCH_OFFSET_MRAD)
                     * 64'sd268435456) / (2000 * h1);
            cordic_sincos(yaw, cy, sy);
            cordic_sincos(pitch, cp, sp);
            rng = (longint'(RANGE_MM) * 65536 + 500) / 1000;
            cam[0] = round_shift(rng * round_shift(cy * cp, 30), 30);
            cam[1] = round_shift(rng * round_shift(sy * cp, 30), 30);
            cam[2] = round_shift(rng * sp, 30);
            in_box = 1;
            for (int i = 0; i < 3; i++) begin
                acc = xform[3*i] * cam[0] + xform[3*i+1] * cam[1] + xform[3*i+2] * cam[2];
                wv = round_shift(acc, 16) + xform[9+i];
                if (!(wv > box_lo[i] && wv < box_hi[i])) in_box = 0;
            end
            o = '0;
            if (d.depth_value == 16'd0 && !in_box) begin
                o.point_x = cam[0][31:0];
                o.point_y = cam[1][31:0];
                o.point_z = cam[2][31:0];
                o.is_free = 1'b1;
            end
            return o;
        endfunction

        function void note_request(t_in d);
            if (d.kind == KIND_LOAD) begin
                if (d.entry_index < XFORM_WORDS) xform[d.entry_index] = longint'(d.entry_value);
            end else begin
                expected_points.push_back(ray_point(d));
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_points.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            if (got.point_x !== want.point_x) begin
                $error("point_x expected %h got %h", want.point_x, got.point_x);
                errors++;
            end
            if (got.point_y !== want.point_y) begin
                $error("point_y expected %h got %h", want.point_y, got.point_y);
                errors++;
            end
            if (got.point_z !== want.point_z) begin
                $error("point_z expected %h got %h", want.point_z, got.point_z);
                errors++;
            end
            if (got.is_free !== want.is_free) begin
                $error("is_free expected %b got %b", want.is_free, got.is_free);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    FreePointBoard board;
    bit            long_hold_req = 0;
    int            cycle_count = 0;
    // The sender shape: 0 means back-to-back requests, otherwise bursts with gaps.
    int            send_mode = 0;

    freespace_ray_point_generator u_top (.*);

    always #2 i_clk = ~i_clk;

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Monitors sample pre-edge values, since all drivers use nonblocking writes.
    always @(posedge i_clk) begin
        if (board != null && i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) board.note_request(i_in_data);
            if (o_out_valid === 1'b1 && !i_out_stall) board.check_result(o_out_data);
        end
    end

    // Receiver stall pattern. The stall density is drawn at random from four modes, and
    // a long hold-off, once requested, is counted out here.
    int hold_left = 0;
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (long_hold_req) begin
            i_out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            long_hold_req <= 0;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= $urandom_range(0, 1);
            endcase
        end
    end

    // Offer one request and hold it until it is taken. Valid stays high into
    // the next request unless a gap follows.
    task automatic send_request(t_in d);
        i_in_valid <= 1'b1;
        i_in_data <= d;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (send_mode != 0 && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic write_box(logic [31:0] lx, logic [31:0] hx, logic [31:0] ly,
                             logic [31:0] hy, logic [31:0] lz, logic [31:0] hz);
        write_reg(CFG_BOX_LOW_X, lx);
        write_reg(CFG_BOX_HIGH_X, hx);
        write_reg(CFG_BOX_LOW_Y, ly);
        write_reg(CFG_BOX_HIGH_Y, hy);
        write_reg(CFG_BOX_LOW_Z, lz);
        write_reg(CFG_BOX_HIGH_Z, hz);
    endtask

    function automatic t_in pixel_request(logic [11:0] col, logic [11:0] row,
                                          logic [15:0] depth);
        t_in d;
        d = '0;
        d.kind = KIND_PIXEL;
        d.pixel_col = col;
        d.pixel_row = row;
        d.depth_value = depth;
        d.entry_index = 4'($urandom);
        d.entry_value = $urandom;
        return d;
    endfunction

    function automatic t_in load_request(logic [3:0] idx, logic [31:0] val);
        t_in d;
        d = '0;
        d.kind = KIND_LOAD;
        d.entry_index = idx;
        d.entry_value = val;
        d.pixel_col = 12'($urandom);
        d.pixel_row = 12'($urandom);
        d.depth_value = 16'($urandom);
        return d;
    endfunction

    // A random request: mostly pixels inside the frame with a zero depth half
    // the time, some pixels anywhere, and a few transform loads.
    function automatic t_in random_request(int w, int h);
        int   pick;
        logic [31:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            if ($urandom_range(0, 3) == 0) val = $urandom;
            else if ($urandom_range(0, 1) == 0) val = $urandom_range(0, 131072) - 65536;
            else val = $urandom_range(0, 1310720) - 655360;
            return load_request(4'($urandom_range(0, 15)), val);
        end else if (pick < 20) begin
            return pixel_request(12'($urandom), 12'($urandom),
                                 $urandom_range(0, 1) ? 16'd0 : 16'($urandom));
        end
        return pixel_request(12'($urandom_range(0, (w > 4096 ? 4096 : w) - 1)),
                             12'($urandom_range(0, (h > 4096 ? 4096 : h) - 1)),
                             $urandom_range(0, 1) ? 16'd0 : 16'($urandom));
    endfunction

    task automatic random_phase(int count, int w, int h);
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) send_mode = $urandom_range(0, 2);
            send_request(random_request(w, h));
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset defaults (empty box, so zero depth is free).
        send_request(pixel_request(12'd0, 12'd0, 16'd0));
        send_request(pixel_request(12'd639, 12'd479, 16'd0));
        send_request(pixel_request(12'd4095, 12'd4095, 16'd0));
        send_request(pixel_request(12'd320, 12'd240, 16'hFFFF));
        send_request(pixel_request(12'd100, 12'd4095, 16'd1));
        send_request(load_request(4'd12, 32'h7FFF_FFFF));
        send_request(load_request(4'd15, 32'h8000_0000));
        send_request(load_request(4'd9, 32'h0001_0000));
        send_request(load_request(4'd11, 32'hFFFF_0000));
        send_request(pixel_request(12'd0, 12'd4095, 16'd0));
        send_request(load_request(4'd1, 32'h8000_0000));
        send_request(load_request(4'd3, 32'h7FFF_FFFF));
        send_request(pixel_request(12'd4095, 12'd0, 16'd0));
        send_request(load_request(4'd1, 32'd0));
        send_request(load_request(4'd3, 32'd0));
        send_request(load_request(4'd9, 32'd0));
        send_request(load_request(4'd11, 32'd0));
        drain();

        // Sizes clamped to two, and a wide box that holds most rays.
        write_reg(CFG_FRAME_WIDTH, 32'd0);
        write_reg(CFG_FRAME_HEIGHT, 32'd1);
        write_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF);
        send_request(pixel_request(12'd0, 12'd0, 16'd0));
        send_request(pixel_request(12'd1, 12'd1, 16'd0));
        send_request(pixel_request(12'd2, 12'd3, 16'd0));
        random_phase(150, 2, 2);
        drain();

        // Largest frame and a 10 m box around the camera; the receiver holds
        // off for a long stretch so the pipeline fills and stalls its input.
        write_reg(CFG_FRAME_WIDTH, 32'd4096);
        write_reg(CFG_FRAME_HEIGHT, 32'd4096);
        write_box(32'hFFF6_0000, 32'h000A_0000, 32'hFFF6_0000, 32'h000A_0000,
                  32'hFFF6_0000, 32'h000A_0000);
        send_mode = 0;
        long_hold_req <= 1;
        random_phase(200, 4096, 4096);
        drain();

        // Frame at the minimum size, degenerate box on one axis.
        write_reg(CFG_FRAME_WIDTH, 32'd2);
        write_reg(CFG_FRAME_HEIGHT, 32'd2);
        write_box(32'hFFF0_0000, 32'h0010_0000, 32'h0005_0000, 32'h0005_0000,
                  32'hFFF0_0000, 32'h0010_0000);
        random_phase(120, 2, 2);
        // Pause in mid phase until every result is back.
        drain();
        random_phase(80, 2, 2);
        drain();

        // Random sizes from 2 to 64 and random boxes.
        for (int p = 0; p < 3; p++) begin
            int w, h;
            w = $urandom_range(2, 64);
            h = $urandom_range(2, 64);
            write_reg(CFG_FRAME_WIDTH, w);
            write_reg(CFG_FRAME_HEIGHT, h);
            write_box($urandom_range(0, 1) ? 32'($urandom) : -$urandom_range(0, 720896),
                      $urandom_range(0, 720896), -$urandom_range(0, 720896),
                      $urandom_range(0, 1) ? 32'($urandom) : $urandom_range(0, 720896),
                      -$urandom_range(0, 720896), $urandom_range(0, 720896));
            random_phase(120, w, h);
            drain();
        end

        if (board.errors == 0 && board.expected_points.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
